FILE: rtl/acds_pkg.sv
// Package: shared constants and types for the audio clock divider search.
`default_nettype none
package acds_pkg;
    localparam int unsigned FreqW   = 32;
    localparam int unsigned TargetW = 20;
    localparam int unsigned BitsW   = 6;
    localparam int unsigned NumSsi  = 6;
    localparam int unsigned MaxDiv  = 255;

    // Map an SSI index to its divider value.
    function automatic logic [4:0] ssi_value(input logic [2:0] idx);
        logic [4:0] v;
        case (idx)
            3'd0:    v = 5'd2;
            3'd1:    v = 5'd4;
            3'd2:    v = 5'd6;
            3'd3:    v = 5'd8;
            3'd4:    v = 5'd12;
            default: v = 5'd16;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

FILE: rtl/audio_clock_divider_search.sv
// Top level: sequencer driving a shared divider over 96 candidate settings.
//
// Channel | Signals                               | Direction
// cfg     | i_cfg_valid/o_cfg_ready, index, data  | in
// in      | i_in_valid/o_in_ready, target, bits   | in
// out     | o_out_valid/i_out_ready, result       | out
//
// The single bit-serial divider is shared by every step of a search: one
// division per source and up to three per candidate, run one after another.
// Reset is synchronous; no clearing pass. The input is not ready while a
// search runs or while a result waits for the output side.
`default_nettype none
module audio_clock_divider_search (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [acds_pkg::TargetW-1:0] i_target_rate,
    input  wire logic [acds_pkg::BitsW-1:0]   i_bits_per_word,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_found,
    output logic [1:0]       o_source_index,
    output logic [1:0]       o_prescale_code,
    output logic [7:0]       o_rate_divisor,
    output logic [4:0]       o_serial_divider,
    output logic [31:0]      o_achieved_rate,
    output logic [31:0]      o_rate_error
);
    import acds_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SSI, S_NDIV, S_NWAIT, S_CODE, S_DDIV, S_DWAIT,
        S_RDIV, S_RWAIT, S_WDIV, S_WWAIT, S_NEXT, S_OUT
    } t_state;

    t_state      r_state;
    logic [31:0] r_freq [4];
    logic [19:0] r_target;
    logic [5:0]  r_bits;
    logic [2:0]  r_s;
    logic [1:0]  r_c;
    logic [1:0]  r_k;
    logic [11:0] r_wclk;
    logic [31:0] r_req;
    logic [31:0] r_n;
    logic [31:0] r_div;
    logic        r_have;
    logic [31:0] r_berr, r_brate;
    logic [1:0]  r_bsrc, r_bcode;
    logic [7:0]  r_bdiv;
    logic [4:0]  r_bssi;
    logic        r_start;
    logic [31:0] r_num, r_den;
    logic        w_done;
    logic [31:0] w_quot;
    logic [31:0] w_b;
    logic [31:0] w_nb;
    logic [31:0] w_err;

    acds_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_num(r_num), .i_den(r_den), .o_done(w_done), .o_quot(w_quot)
    );

    assign w_b   = 32'd1 << {r_k, 1'b0};
    assign w_nb  = r_n - w_b;
    assign w_err = (w_quot > {12'd0, r_target}) ? (w_quot - {12'd0, r_target})
                                                : ({12'd0, r_target} - w_quot);

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    // Write source frequency registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_freq[i] <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_freq[i_cfg_index] <= i_cfg_data;
        end
    end

    // Sequence candidates through the divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
            r_have  <= 1'b0;
        end else begin
            r_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_target <= i_target_rate;
                        r_bits   <= i_bits_per_word;
                        r_s      <= '0;
                        r_have   <= 1'b0;
                        r_berr <= '0; r_brate <= '0; r_bsrc <= '0;
                        r_bcode <= '0; r_bdiv <= '0; r_bssi <= '0;
                        r_state  <= S_SSI;
                    end
                end
                S_SSI: begin
                    r_wclk  <= 12'({r_bits, 1'b0} * ssi_value(r_s));
                    r_req   <= 32'({r_bits, 1'b0} * ssi_value(r_s)) * {12'd0, r_target};
                    r_c     <= '0;
                    r_state <= S_NDIV;
                end
                S_NDIV: begin
                    if (r_req == 32'd0) begin
                        r_c     <= 2'd3;
                        r_state <= S_NEXT;
                        r_k     <= 2'd3;
                    end else begin
                        r_num <= r_freq[r_c]; r_den <= r_req;
                        r_start <= 1'b1; r_state <= S_NWAIT;
                    end
                end
                S_NWAIT: if (w_done) begin
                    r_n <= w_quot; r_k <= '0; r_state <= S_CODE;
                end
                S_CODE: begin
                    if (r_n < w_b) begin
                        r_div   <= '0;
                        r_state <= S_RDIV;
                    end else begin
                        r_num <= w_nb; r_den <= w_b << 1;
                        r_start <= 1'b1; r_state <= S_DWAIT;
                    end
                end
                S_DWAIT: if (w_done) begin
                    r_div   <= w_quot;
                    r_state <= (w_quot > MaxDiv) ? S_NEXT : S_RDIV;
                end
                S_RDIV: begin
                    r_num <= r_freq[r_c];
                    r_den <= (w_b << 1) * (r_div + 32'd1);
                    r_start <= 1'b1; r_state <= S_RWAIT;
                end
                S_RWAIT: if (w_done) begin
                    r_num <= w_quot; r_den <= {20'd0, r_wclk};
                    r_start <= 1'b1; r_state <= S_WWAIT;
                end
                S_WWAIT: if (w_done) begin
                    if (!r_have || w_err < r_berr) begin
                        r_have <= 1'b1; r_berr <= w_err; r_brate <= w_quot;
                        r_bsrc <= r_c; r_bcode <= r_k; r_bdiv <= r_div[7:0];
                        r_bssi <= ssi_value(r_s);
                    end
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    if (r_k != 2'd3) begin
                        r_k <= r_k + 2'd1; r_state <= S_CODE;
                    end else if (r_c != 2'd3) begin
                        r_c <= r_c + 2'd1; r_state <= S_NDIV;
                    end else if (r_s != 3'(NumSsi - 1)) begin
                        r_s <= r_s + 3'd1; r_state <= S_SSI;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_found          = r_have;
    assign o_source_index   = r_bsrc;
    assign o_prescale_code  = r_bcode;
    assign o_rate_divisor   = r_bdiv;
    assign o_serial_divider = r_bssi;
    assign o_achieved_rate  = r_brate;
    assign o_rate_error     = r_berr;
endmodule
`default_nettype wire

FILE: rtl/acds_div.sv
// Shared 32-bit restoring divider, one quotient bit per cycle.
`default_nettype none
module acds_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_done,
    output logic [31:0]      o_quot
);
    logic [31:0] r_quot;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] w_shift;
    logic [32:0] w_sub;

    assign w_shift = {r_rem[31:0], r_quot[31]};
    assign w_sub   = w_shift - {1'b0, r_den};

    // Step one bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_quot <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!w_sub[32]) begin
                    r_rem  <= w_sub;
                    r_quot <= {r_quot[30:0], 1'b1};
                end else begin
                    r_rem  <= w_shift;
                    r_quot <= {r_quot[30:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
`default_nettype wire

FILE: test/tb_audio_clock_divider_search.sv
// Testbench for the audio clock divider search: directed table, random items, scoreboard.
`timescale 1ns / 1ps
module tb_audio_clock_divider_search;
    import acds_pkg::*;

    localparam int unsigned SearchCycles = 11000;
    localparam int unsigned WatchLimit   = 400000;
    localparam int unsigned NumDirected  = 14;

    typedef struct packed {
        logic        found;
        logic [1:0]  source_index;
        logic [1:0]  prescale_code;
        logic [7:0]  rate_divisor;
        logic [4:0]  serial_divider;
        logic [31:0] achieved_rate;
        logic [31:0] rate_error;
    } t_clock_choice;

    typedef struct {
        logic [TargetW-1:0] target;
        logic [BitsW-1:0]   bits;
        bit                 typed;
        t_clock_choice      choice;
    } t_request_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [TargetW-1:0] i_target_rate = '0;
    logic [BitsW-1:0]   i_bits_per_word = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_found;
    logic [1:0]  o_source_index;
    logic [1:0]  o_prescale_code;
    logic [7:0]  o_rate_divisor;
    logic [4:0]  o_serial_divider;
    logic [31:0] o_achieved_rate;
    logic [31:0] o_rate_error;

    logic [31:0]   clock_freq [4];
    t_clock_choice pending_choices [$];
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    bit            hold_off = 1'b0;
    bit            failed = 1'b0;
    int            quiet_cycles = 0;

    audio_clock_divider_search uut (.*);

    always #2 i_clk = ~i_clk;

    // Search all 96 candidates for the closest achievable sample rate.
    function automatic t_clock_choice best_clock(input logic [TargetW-1:0] target,
                                                 input logic [BitsW-1:0] bits);
        t_clock_choice best;
        logic [4:0]  dividers [6] = '{5'd2, 5'd4, 5'd6, 5'd8, 5'd12, 5'd16};
        bit          have;
        logic [31:0] word_clk, needed, n, b, div, rate, err;
        best = '0;
        have = 0;
        for (int s = 0; s < 6; s++) begin
            word_clk = 32'(bits) * 2 * 32'(dividers[s]);
            needed = word_clk * 32'(target);
            if (needed == 0) continue;
            for (int c = 0; c < 4; c++) begin
                n = clock_freq[c] / needed;
                for (int k = 0; k < 4; k++) begin
                    b = 32'd1 << (2 * k);
                    div = (n < b) ? 32'd0 : (n - b) / (2 * b);
                    if (div > MaxDiv) continue;
                    rate = (clock_freq[c] / (b * 2 * (div + 1))) / word_clk;
                    err = (rate > 32'(target)) ? rate - 32'(target) : 32'(target) - rate;
                    if (!have || err < best.rate_error) begin
                        have = 1;
                        best = '{1'b1, 2'(c), 2'(k), 8'(div), dividers[s], rate, err};
                    end
                end
            end
        end
        return best;
    endfunction

    // Write one clock frequency register.
    task automatic write_clock(input logic [1:0] idx, input logic [31:0] value);
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        clock_freq[idx] = value;
        @(posedge i_clk);
    endtask

    // Offer one request, holding it until accepted, and queue its expectation.
    task automatic send_request(input logic [TargetW-1:0] target, input logic [BitsW-1:0] bits,
                                input bit typed, input t_clock_choice choice);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        i_target_rate   <= target;
        i_bits_per_word <= bits;
        i_in_valid      <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pending_choices.push_back(typed ? choice : best_clock(target, bits));
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drain expectations, then let the block settle before touching registers.
    task automatic wait_idle();
        while (pending_choices.size() != 0) @(posedge i_clk);
        repeat (SearchCycles) @(posedge i_clk);
    endtask

    // Drive the receiver's ready.
    always @(posedge i_clk) begin
        i_out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge i_clk) begin
        t_clock_choice want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_choices.size() == 0) begin
                $error("unexpected result transaction");
                failed = 1'b1;
            end else begin
                want = pending_choices.pop_front();
                if (o_found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_found);
                    failed = 1'b1;
                end
                if (o_source_index !== want.source_index) begin
                    $error("source_index: expected %0d, got %0d",
                           want.source_index, o_source_index);
                    failed = 1'b1;
                end
                if (o_prescale_code !== want.prescale_code) begin
                    $error("prescale_code: expected %0d, got %0d",
                           want.prescale_code, o_prescale_code);
                    failed = 1'b1;
                end
                if (o_rate_divisor !== want.rate_divisor) begin
                    $error("rate_divisor: expected %0d, got %0d",
                           want.rate_divisor, o_rate_divisor);
                    failed = 1'b1;
                end
                if (o_serial_divider !== want.serial_divider) begin
                    $error("serial_divider: expected %0d, got %0d",
                           want.serial_divider, o_serial_divider);
                    failed = 1'b1;
                end
                if (o_achieved_rate !== want.achieved_rate) begin
                    $error("achieved_rate: expected %0d, got %0d",
                           want.achieved_rate, o_achieved_rate);
                    failed = 1'b1;
                end
                if (o_rate_error !== want.rate_error) begin
                    $error("rate_error: expected %0d, got %0d",
                           want.rate_error, o_rate_error);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog: end the run after too long without any transaction.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Long receiver hold-off while requests keep coming.
    task automatic hold_receiver();
        hold_off = 1'b1;
        repeat (3 * SearchCycles) @(posedge i_clk);
        hold_off = 1'b0;
    endtask

    initial begin
        t_request_row directed [NumDirected];
        logic [31:0] base_freqs [4];
        t_clock_choice none;
        none = '0;
        foreach (clock_freq[i]) clock_freq[i] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers still zero after reset: every candidate reaches a rate of zero,
        // so the first one wins with the whole target as its error.
        send_request(20'd48000, 6'd16, 1,
                     t_clock_choice'{1'b1, 2'd0, 2'd0, 8'd0, 5'd2, 32'd0, 32'd48000});
        send_request(20'hFFFFF, 6'd63, 1,
                     t_clock_choice'{1'b1, 2'd0, 2'd0, 8'd0, 5'd2, 32'd0, 32'd1048575});
        wait_idle();

        write_clock(2'd0, 32'd24576000);
        write_clock(2'd1, 32'd22579200);
        write_clock(2'd2, 32'd12288000);
        write_clock(2'd3, 32'd66000000);

        directed = '{
            '{20'd0, 6'd16, 1, none},
            '{20'd48000, 6'd0, 1, none},
            '{20'd0, 6'd0, 1, none},
            '{20'd1, 6'd1, 0, none},
            '{20'd48000, 6'd16, 0, none},
            '{20'd44100, 6'd16, 0, none},
            '{20'd768000, 6'd32, 0, none},
            '{20'd8000, 6'd24, 0, none},
            '{20'hFFFFF, 6'd63, 0, none},
            '{20'h55555, 6'h2A, 0, none},
            '{20'hAAAAA, 6'h15, 0, none},
            '{20'd96000, 6'd32, 0, none},
            '{20'd1, 6'd63, 0, none},
            '{20'd16000, 6'd8, 0, none}
        };
        foreach (directed[i])
            send_request(directed[i].target, directed[i].bits,
                         directed[i].typed, directed[i].choice);
        wait_idle();

        // Extreme clocks, then random clocks, across the idling phases.
        base_freqs = '{32'hFFFFFFFF, 32'd1, 32'h80000000, 32'd49152000};
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            for (int r = 0; r < 4; r++)
                write_clock(2'(r), phase == 0 ? base_freqs[r] : $urandom());
            fork
                if (phase == 2) hold_receiver();
                for (int n = 0; n < 22; n++) begin
                    if ($urandom_range(3) == 0)
                        send_request(20'($urandom()), 6'($urandom()), 0, none);
                    else
                        send_request(20'($urandom_range(768000, 1)),
                                     6'($urandom_range(32, 1)), 0, none);
                end
            join
            wait_idle();
        end

        if (!failed)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
